/* rtl/ray_box_edge_crossing_assert.svh */
`ifndef RAY_BOX_EDGE_CROSSING_ASSERT_SVH
`define RAY_BOX_EDGE_CROSSING_ASSERT_SVH

// same-cycle implication
`define RBEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RBEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rbec_pkg.sv */
package rbec_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int DIR_FRAC = 15;
  localparam int REACH_W = 24;
  localparam int TOL_W   = 32;
  localparam int PROD_W  = DIR_W + REACH_W + 1;
  localparam int OFF_W   = PROD_W + 1 - DIR_FRAC;
  localparam int FAR_W   = COORD_W + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_W   = 2 * DIFF_W;
  localparam int SUM_W   = MUL_W + 1;
  localparam int NTERM   = 8;
  localparam int NONSEG  = 4;
  localparam int NEDGE   = 4;

  localparam logic [0:0] CfgReach = 1'b0;
  localparam logic [0:0] CfgTol   = 1'b1;

  localparam logic [REACH_W-1:0] ReachReset = REACH_W'(100000);
  localparam logic [TOL_W-1:0]   TolReset   = '0;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } rbec_pt_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } rbec_adv_t;

endpackage

/* rtl/rbec_seg.sv */
module rbec_seg import rbec_pkg::*; (
  input  logic                     clk_i,
  input  rbec_adv_t                adv_i,
  input  rbec_pt_t                 p1_i,
  input  rbec_pt_t                 p2_i,
  input  rbec_pt_t                 p3_i,
  input  rbec_pt_t                 p4_i,
  output logic signed [SUM_W-1:0]  cross_o [NTERM],
  output logic signed [SUM_W-1:0]  dot_o [NTERM]
);

  rbec_pt_t base [NTERM];
  rbec_pt_t pa [NTERM];
  rbec_pt_t pb [NTERM];

  logic signed [DIFF_W-1:0] ux_q [NTERM];
  logic signed [DIFF_W-1:0] uy_q [NTERM];
  logic signed [DIFF_W-1:0] vx_q [NTERM];
  logic signed [DIFF_W-1:0] vy_q [NTERM];
  logic signed [MUL_W-1:0]  pxy_q [NTERM];
  logic signed [MUL_W-1:0]  pyx_q [NTERM];
  logic signed [MUL_W-1:0]  pxx_q [NTERM];
  logic signed [MUL_W-1:0]  pyy_q [NTERM];
  logic signed [SUM_W-1:0]  cross_q [NTERM];
  logic signed [SUM_W-1:0]  dot_q [NTERM];

  // endpoint-on-segment terms, then the four orientation terms
  always_comb begin
    base[0] = p1_i; pa[0] = p3_i; pb[0] = p4_i;
    base[1] = p2_i; pa[1] = p3_i; pb[1] = p4_i;
    base[2] = p3_i; pa[2] = p1_i; pb[2] = p2_i;
    base[3] = p4_i; pa[3] = p1_i; pb[3] = p2_i;
    base[4] = p1_i; pa[4] = p2_i; pb[4] = p3_i;
    base[5] = p1_i; pa[5] = p2_i; pb[5] = p4_i;
    base[6] = p3_i; pa[6] = p4_i; pb[6] = p1_i;
    base[7] = p3_i; pa[7] = p4_i; pb[7] = p2_i;
  end

  for (genvar k = 0; k < NTERM; k++) begin : g_term
    always_ff @(posedge clk_i) begin
      if (adv_i.s3) begin
        ux_q[k] <= DIFF_W'(pa[k].x) - DIFF_W'(base[k].x);
        uy_q[k] <= DIFF_W'(pa[k].y) - DIFF_W'(base[k].y);
        vx_q[k] <= DIFF_W'(pb[k].x) - DIFF_W'(base[k].x);
        vy_q[k] <= DIFF_W'(pb[k].y) - DIFF_W'(base[k].y);
      end
      if (adv_i.s4) begin
        pxy_q[k] <= MUL_W'(ux_q[k]) * MUL_W'(vy_q[k]);
        pyx_q[k] <= MUL_W'(uy_q[k]) * MUL_W'(vx_q[k]);
        pxx_q[k] <= MUL_W'(ux_q[k]) * MUL_W'(vx_q[k]);
        pyy_q[k] <= MUL_W'(uy_q[k]) * MUL_W'(vy_q[k]);
      end
      if (adv_i.s5) begin
        cross_q[k] <= SUM_W'(pxy_q[k]) - SUM_W'(pyx_q[k]);
        dot_q[k]   <= SUM_W'(pxx_q[k]) + SUM_W'(pyy_q[k]);
      end
    end
    assign cross_o[k] = cross_q[k];
    assign dot_o[k]   = dot_q[k];
  end

endmodule

/* rtl/ray_box_edge_crossing.sv */
// channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | origin, dir, box corners
// out      | out_valid_o / out_ready_i  | hit_o
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// one transaction per cycle while the output is not stalled; the result is registered through the stages below
// stages: reach multiply, far point, differences, 33x33 products, sums, edge tests
// each stage moves when the one after it is empty or moving, so bubbles collapse
// reset clears valid bits and loads the register defaults; cfg is always ready
module ray_box_edge_crossing import rbec_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_W-1:0]  origin_x_i,
  input  logic signed [COORD_W-1:0]  origin_y_i,
  input  logic signed [DIR_W-1:0]    dir_x_i,
  input  logic signed [DIR_W-1:0]    dir_y_i,
  input  logic signed [COORD_W-1:0]  box_min_x_i,
  input  logic signed [COORD_W-1:0]  box_min_y_i,
  input  logic signed [COORD_W-1:0]  box_max_x_i,
  input  logic signed [COORD_W-1:0]  box_max_y_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [TOL_W-1:0]           cfg_data_i
);

  localparam logic signed [FAR_W-1:0] FarMax = FAR_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [FAR_W-1:0] FarMin = FAR_W'(-(64'sd1 <<< (COORD_W - 1)));
  localparam logic signed [PROD_W:0]  RoundHalf = (PROD_W+1)'(64'sd1 <<< (DIR_FRAC - 1));

  logic [REACH_W-1:0] reach_q;
  logic [TOL_W-1:0]   tol_q;

  logic [6:1] v_q;
  logic [6:1] en;

  rbec_pt_t org1_q, bmin1_q, bmax1_q;
  logic signed [PROD_W-1:0] prodx1_q, prody1_q;
  rbec_pt_t org2_q, far2_q, bmin2_q, bmax2_q, c1, c2;
  logic signed [OFF_W-1:0] offx, offy;
  logic signed [FAR_W-1:0] sumx, sumy;
  logic signed [COORD_W-1:0] farx, fary;
  rbec_adv_t adv;
  logic hit_q;
  logic [NEDGE-1:0] meet;
  logic signed [SUM_W-1:0] tol_pos, tol_neg;

  logic signed [SUM_W-1:0] cross_w [NEDGE][NTERM];
  logic signed [SUM_W-1:0] dot_w [NEDGE][NTERM];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= ReachReset;
      tol_q   <= TolReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgReach: reach_q <= cfg_data_i[REACH_W-1:0];
        CfgTol:   tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[6] = !v_q[6] || out_ready_i;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // reach multiply
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      org1_q   <= '{x: origin_x_i, y: origin_y_i};
      bmin1_q  <= '{x: box_min_x_i, y: box_min_y_i};
      bmax1_q  <= '{x: box_max_x_i, y: box_max_y_i};
      prodx1_q <= PROD_W'(dir_x_i) * $signed(PROD_W'(reach_q));
      prody1_q <= PROD_W'(dir_y_i) * $signed(PROD_W'(reach_q));
    end
  end

  // round half up, then saturate the far point
  always_comb begin
    logic signed [PROD_W:0] qx, qy;
    qx   = (PROD_W+1)'(prodx1_q) + RoundHalf;
    qy   = (PROD_W+1)'(prody1_q) + RoundHalf;
    offx = OFF_W'(qx >>> DIR_FRAC);
    offy = OFF_W'(qy >>> DIR_FRAC);
    sumx = FAR_W'(org1_q.x) + FAR_W'(offx);
    sumy = FAR_W'(org1_q.y) + FAR_W'(offy);
    if (sumx > FarMax)      farx = COORD_W'(FarMax);
    else if (sumx < FarMin) farx = COORD_W'(FarMin);
    else                    farx = COORD_W'(sumx);
    if (sumy > FarMax)      fary = COORD_W'(FarMax);
    else if (sumy < FarMin) fary = COORD_W'(FarMin);
    else                    fary = COORD_W'(sumy);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      org2_q  <= org1_q;
      bmin2_q <= bmin1_q;
      bmax2_q <= bmax1_q;
      far2_q  <= '{x: farx, y: fary};
    end
  end

  assign c1  = '{x: bmin2_q.x, y: bmax2_q.y};
  assign c2  = '{x: bmax2_q.x, y: bmin2_q.y};
  assign adv = '{s3: en[3], s4: en[4], s5: en[5]};

  rbec_seg u_seg0 (.clk_i, .adv_i(adv), .p1_i(org2_q), .p2_i(far2_q),
                   .p3_i(bmin2_q), .p4_i(c1), .cross_o(cross_w[0]), .dot_o(dot_w[0]));
  rbec_seg u_seg1 (.clk_i, .adv_i(adv), .p1_i(org2_q), .p2_i(far2_q),
                   .p3_i(bmin2_q), .p4_i(c2), .cross_o(cross_w[1]), .dot_o(dot_w[1]));
  rbec_seg u_seg2 (.clk_i, .adv_i(adv), .p1_i(org2_q), .p2_i(far2_q),
                   .p3_i(bmax2_q), .p4_i(c1), .cross_o(cross_w[2]), .dot_o(dot_w[2]));
  rbec_seg u_seg3 (.clk_i, .adv_i(adv), .p1_i(org2_q), .p2_i(far2_q),
                   .p3_i(bmax2_q), .p4_i(c2), .cross_o(cross_w[3]), .dot_o(dot_w[3]));

  assign tol_pos = SUM_W'({1'b0, tol_q});
  assign tol_neg = -tol_pos;

  always_comb begin
    logic [NONSEG-1:0] on_seg;
    logic [NTERM-1:NONSEG] neg, pos;
    for (int e = 0; e < NEDGE; e++) begin
      for (int k = 0; k < NONSEG; k++) begin
        on_seg[k] = (cross_w[e][k] <= tol_pos) && (cross_w[e][k] >= tol_neg) &&
                    (dot_w[e][k] <= 0);
      end
      for (int k = NONSEG; k < NTERM; k++) begin
        neg[k] = cross_w[e][k][SUM_W-1];
        pos[k] = !neg[k] && (cross_w[e][k] != 0);
      end
      meet[e] = (|on_seg) ||
                (((neg[4] && pos[5]) || (pos[4] && neg[5])) &&
                 ((neg[6] && pos[7]) || (pos[6] && neg[7])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) hit_q <= |meet;
  end

  assign out_valid_o = v_q[6];
  assign hit_o       = hit_q;

endmodule

/* rtl/rbec_checker.sv */
`include "ray_box_edge_crossing_assert.svh"

module rbec_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic hit_o
);

  `RBEC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(hit_o))
  `RBEC_ASSERT_NOW(a_ready_flows, out_ready_i, in_ready_o)
  `RBEC_ASSERT_NOW(a_stall_full, !in_ready_o, out_valid_o)

endmodule

bind ray_box_edge_crossing rbec_checker u_rbec_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .hit_o(hit_o)
);
